FILE: rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths, codes and types of the homography point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int PIX_W          = 16;
	localparam int COORD_INT_BITS = 12;
	localparam int PIX_FRAC       = PIX_W - COORD_INT_BITS;
	localparam int COEF_W         = 48;
	localparam int COEF_FRAC      = 32;
	localparam int WORLD_W        = 48;
	localparam int WORLD_FRAC     = 16;
	localparam int PROD_W         = COEF_W + PIX_W + 1;
	localparam int SUM_W          = PROD_W + 1;
	localparam int MAG_W          = SUM_W - 1;
	localparam int DIV_STEPS      = WORLD_W;
	localparam int HI_W           = MAG_W + WORLD_FRAC - DIV_STEPS;
	localparam int LATENCY        = DIV_STEPS + 6;

	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;

	localparam logic [2:0] REG_XX = 3'd0;
	localparam logic [2:0] REG_XY = 3'd1;
	localparam logic [2:0] REG_XO = 3'd2;
	localparam logic [2:0] REG_YX = 3'd3;
	localparam logic [2:0] REG_YY = 3'd4;
	localparam logic [2:0] REG_YO = 3'd5;
	localparam logic [2:0] REG_PX = 3'd6;
	localparam logic [2:0] REG_PY = 3'd7;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_DEN = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	localparam logic [WORLD_W-1:0] WORLD_MAX = {1'b0, {(WORLD_W-1){1'b1}}};
	localparam logic [WORLD_W-1:0] WORLD_MIN = {1'b1, {(WORLD_W-1){1'b0}}};

	typedef struct packed {
		logic [COEF_W-1:0] xx;
		logic [COEF_W-1:0] xy;
		logic [COEF_W-1:0] xo;
		logic [COEF_W-1:0] yx;
		logic [COEF_W-1:0] yy;
		logic [COEF_W-1:0] yo;
		logic [COEF_W-1:0] px;
		logic [COEF_W-1:0] py;
	} coef_t;

	typedef struct packed {
		logic valid;
		logic flag;
	} div_ctl_t;

endpackage

FILE: rtl/core/homography_point_transform.sv
// Pipeline from the edge that accepts start to done: 3 front-end stages, divider
// entry, 48 divider stages, saturation stage, output stage.
// Throughput: one point per cycle; busy stays low, every stage advances each cycle.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset clears all valid bits; coefficients return to the identity transform.
// ----------------------------------------------------------------------------
// homography_point_transform
// Projects a pixel point through a 3x3 planar homography into world units.
// ----------------------------------------------------------------------------
module homography_point_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hpt_pkg::PIX_W-1:0]     pixel_x,
	input  logic [hpt_pkg::PIX_W-1:0]     pixel_y,
	output logic                          done,
	output logic [hpt_pkg::WORLD_W-1:0]   world_x,
	output logic [hpt_pkg::WORLD_W-1:0]   world_y,
	output logic [1:0]                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hpt_pkg::ADDR_W-1:0]    paddr,
	input  logic [hpt_pkg::DATA_W-1:0]    pwdata,
	output logic [hpt_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	hpt_pkg::coef_t                coef;
	logic                          m_valid, m_negx, m_negy, m_bad;
	logic [hpt_pkg::MAG_W-1:0]     m_magx, m_magy, m_den;
	hpt_pkg::div_ctl_t             dctl, xctl, yctl;
	logic [hpt_pkg::WORLD_W-1:0]   qx, qy;
	logic                          satx, saty;

	logic                          done_q;
	logic [hpt_pkg::WORLD_W-1:0]   wx_q, wy_q;
	logic [1:0]                    st_q;

	assign busy = 1'b0;

	hpt_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .coef(coef)
	);

	hpt_mac u_mac (
		.clk(clk), .arst_n(arst_n), .in_valid(start & ~busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .coef(coef),
		.valid(m_valid), .mag_x(m_magx), .neg_x(m_negx), .mag_y(m_magy), .neg_y(m_negy),
		.den(m_den), .bad(m_bad)
	);

	assign dctl.valid = m_valid;
	assign dctl.flag  = m_bad;

	hpt_div u_div_x (
		.clk(clk), .arst_n(arst_n), .ctl_in(dctl), .mag(m_magx), .neg(m_negx),
		.den(m_den), .ctl_out(xctl), .quot(qx), .sat(satx)
	);

	hpt_div u_div_y (
		.clk(clk), .arst_n(arst_n), .ctl_in(dctl), .mag(m_magy), .neg(m_negy),
		.den(m_den), .ctl_out(yctl), .quot(qy), .sat(saty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= xctl.valid & yctl.valid;
	end

	// drop the quotients when the denominator is not positive
	always_ff @(posedge clk) begin
		if (xctl.flag | yctl.flag) begin
			wx_q <= '0;
			wy_q <= '0;
			st_q <= hpt_pkg::ST_BAD_DEN;
		end else begin
			wx_q <= qx;
			wy_q <= qy;
			st_q <= (satx | saty) ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
		end
	end

	assign done    = done_q;
	assign world_x = wx_q;
	assign world_y = wy_q;
	assign status  = st_q;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(hpt_pkg::LATENCY) done)
		else $error("accepted point produced no result");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, hpt_pkg::LATENCY))
		else $error("result without an accepted point");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == hpt_pkg::ST_BAD_DEN |-> world_x == '0 && world_y == '0)
		else $error("rejected denominator with nonzero coordinates");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3)
		else $error("undefined status code");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		xctl.valid == yctl.valid)
		else $error("divider lanes out of step");
`endif

endmodule

FILE: rtl/core/hpt_regs.sv
// ----------------------------------------------------------------------------
// hpt_regs
// Coefficient register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module hpt_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hpt_pkg::ADDR_W-1:0] paddr,
	input  logic [hpt_pkg::DATA_W-1:0] pwdata,
	output logic [hpt_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output hpt_pkg::coef_t             coef
);

	hpt_pkg::coef_t           coef_q;
	logic [2:0]               idx;
	logic                     wr_en;
	logic [hpt_pkg::COEF_W-1:0] wval;
	logic [hpt_pkg::COEF_W-1:0] rval;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel & penable & pwrite & pready;
	assign wval   = pwdata[hpt_pkg::COEF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.xx <= hpt_pkg::COEF_ONE;
			coef_q.xy <= '0;
			coef_q.xo <= '0;
			coef_q.yx <= '0;
			coef_q.yy <= hpt_pkg::COEF_ONE;
			coef_q.yo <= '0;
			coef_q.px <= '0;
			coef_q.py <= '0;
		end else if (wr_en) begin
			case (idx)
				hpt_pkg::REG_XX: coef_q.xx <= wval;
				hpt_pkg::REG_XY: coef_q.xy <= wval;
				hpt_pkg::REG_XO: coef_q.xo <= wval;
				hpt_pkg::REG_YX: coef_q.yx <= wval;
				hpt_pkg::REG_YY: coef_q.yy <= wval;
				hpt_pkg::REG_YO: coef_q.yo <= wval;
				hpt_pkg::REG_PX: coef_q.px <= wval;
				hpt_pkg::REG_PY: coef_q.py <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			hpt_pkg::REG_XX: rval = coef_q.xx;
			hpt_pkg::REG_XY: rval = coef_q.xy;
			hpt_pkg::REG_XO: rval = coef_q.xo;
			hpt_pkg::REG_YX: rval = coef_q.yx;
			hpt_pkg::REG_YY: rval = coef_q.yy;
			hpt_pkg::REG_YO: rval = coef_q.yo;
			hpt_pkg::REG_PX: rval = coef_q.px;
			hpt_pkg::REG_PY: rval = coef_q.py;
			default:         rval = '0;
		endcase
	end

	assign prdata = {{(hpt_pkg::DATA_W-hpt_pkg::COEF_W){1'b0}}, rval};
	assign coef   = coef_q;

endmodule

FILE: rtl/core/hpt_mac.sv
// ----------------------------------------------------------------------------
// hpt_mac
// Three-stage front end: products, exact sums, numerator magnitudes.
// ----------------------------------------------------------------------------
module hpt_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [hpt_pkg::PIX_W-1:0]   pixel_x,
	input  logic [hpt_pkg::PIX_W-1:0]   pixel_y,
	input  hpt_pkg::coef_t              coef,
	output logic                        valid,
	output logic [hpt_pkg::MAG_W-1:0]   mag_x,
	output logic                        neg_x,
	output logic [hpt_pkg::MAG_W-1:0]   mag_y,
	output logic                        neg_y,
	output logic [hpt_pkg::MAG_W-1:0]   den,
	output logic                        bad
);

	localparam int SW = hpt_pkg::SUM_W;
	localparam int PW = hpt_pkg::PROD_W;
	localparam int CW = hpt_pkg::COEF_W;
	localparam int MAG_W_L = hpt_pkg::MAG_W;

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1, p_px_s1, p_py_s1;
	logic signed [SW-1:0] nx_s2, ny_s2, dn_s2;
	logic [MAG_W_L-1:0]   mx_s3, my_s3, dn_s3;
	logic                 nxneg_s3, nyneg_s3, bad_s3;

	logic signed [PW-1:0] sx, sy;
	logic [SW-1:0]        off_x, off_y, one_den;
	logic [SW-1:0]        nx_abs, ny_abs;

	assign sx      = {{(PW-hpt_pkg::PIX_W){1'b0}}, pixel_x};
	assign sy      = {{(PW-hpt_pkg::PIX_W){1'b0}}, pixel_y};
	assign off_x   = {{(SW-CW){coef.xo[CW-1]}}, coef.xo} << hpt_pkg::PIX_FRAC;
	assign off_y   = {{(SW-CW){coef.yo[CW-1]}}, coef.yo} << hpt_pkg::PIX_FRAC;
	assign one_den = SW'(1) << (hpt_pkg::COEF_FRAC + hpt_pkg::PIX_FRAC);
	assign nx_abs  = nx_s2[SW-1] ? (~nx_s2 + SW'(1)) : nx_s2;
	assign ny_abs  = ny_s2[SW-1] ? (~ny_s2 + SW'(1)) : ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_xx_s1 <= PW'($signed(coef.xx) * sx);
		p_xy_s1 <= PW'($signed(coef.xy) * sy);
		p_yx_s1 <= PW'($signed(coef.yx) * sx);
		p_yy_s1 <= PW'($signed(coef.yy) * sy);
		p_px_s1 <= PW'($signed(coef.px) * sx);
		p_py_s1 <= PW'($signed(coef.py) * sy);

		nx_s2 <= {p_xx_s1[PW-1], p_xx_s1} + {p_xy_s1[PW-1], p_xy_s1} + off_x;
		ny_s2 <= {p_yx_s1[PW-1], p_yx_s1} + {p_yy_s1[PW-1], p_yy_s1} + off_y;
		dn_s2 <= {p_px_s1[PW-1], p_px_s1} + {p_py_s1[PW-1], p_py_s1} + one_den;

		mx_s3    <= nx_abs[MAG_W_L-1:0];
		my_s3    <= ny_abs[MAG_W_L-1:0];
		nxneg_s3 <= nx_s2[SW-1];
		nyneg_s3 <= ny_s2[SW-1];
		dn_s3    <= dn_s2[MAG_W_L-1:0];
		bad_s3   <= dn_s2[SW-1] | (dn_s2 == '0);
	end

	assign valid = vld_s3;
	assign mag_x = mx_s3;
	assign neg_x = nxneg_s3;
	assign mag_y = my_s3;
	assign neg_y = nyneg_s3;
	assign den   = dn_s3;
	assign bad   = bad_s3;

endmodule

FILE: rtl/core/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider: one quotient bit per stage, signed saturate.
// ----------------------------------------------------------------------------
module hpt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpt_pkg::div_ctl_t             ctl_in,
	input  logic [hpt_pkg::MAG_W-1:0]     mag,
	input  logic                          neg,
	input  logic [hpt_pkg::MAG_W-1:0]     den,
	output hpt_pkg::div_ctl_t             ctl_out,
	output logic [hpt_pkg::WORLD_W-1:0]   quot,
	output logic                          sat
);

	localparam int MW = hpt_pkg::MAG_W;
	localparam int NS = hpt_pkg::DIV_STEPS;
	localparam int HW = hpt_pkg::HI_W;
	localparam int WW = hpt_pkg::WORLD_W;

	hpt_pkg::div_ctl_t ctl_s [0:NS];
	logic [MW-1:0]     rem_s [0:NS];
	logic [MW-1:0]     den_s [0:NS];
	logic [NS-1:0]     low_s [0:NS];
	logic [NS-1:0]     q_s   [0:NS];
	logic              neg_s [0:NS];
	logic              ovf_s [0:NS];

	hpt_pkg::div_ctl_t ctl_q;
	logic [WW-1:0]     quot_q;
	logic              sat_q;

	logic [HW-1:0]     hi;
	logic              ovf_in;
	logic              sat_pos, sat_neg;
	logic [NS-1:0]     qf;

	assign hi     = mag[MW-1:MW-HW];
	assign ovf_in = {{(MW-HW){1'b0}}, hi} >= den;

	// entry: top bits become the starting remainder; a full one means overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else         ctl_s[0] <= ctl_in;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= {{(MW-HW){1'b0}}, hi};
		den_s[0] <= den;
		low_s[0] <= {mag[MW-HW-1:0], {hpt_pkg::WORLD_FRAC{1'b0}}};
		q_s[0]   <= '0;
		neg_s[0] <= neg;
		ovf_s[0] <= ovf_in;
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [MW:0]   rsh;
		logic [MW+1:0] diff;

		assign rsh  = {rem_s[k], low_s[k][NS-1]};
		assign diff = {1'b0, rsh} - {2'b00, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[k+1] <= '0;
			else         ctl_s[k+1] <= ctl_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= diff[MW+1] ? rsh[MW-1:0] : diff[MW-1:0];
			q_s[k+1]   <= {q_s[k][NS-2:0], ~diff[MW+1]};
			low_s[k+1] <= {low_s[k][NS-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign qf      = q_s[NS];
	assign sat_pos = ovf_s[NS] | qf[NS-1];
	assign sat_neg = ovf_s[NS] | (qf[NS-1] & (|qf[NS-2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else         ctl_q <= ctl_s[NS];
	end

	always_ff @(posedge clk) begin
		if (neg_s[NS]) begin
			quot_q <= sat_neg ? hpt_pkg::WORLD_MIN : (~qf + WW'(1));
			sat_q  <= sat_neg;
		end else begin
			quot_q <= sat_pos ? hpt_pkg::WORLD_MAX : qf;
			sat_q  <= sat_pos;
		end
	end

	assign ctl_out = ctl_q;
	assign quot    = quot_q;
	assign sat     = sat_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of homography_point_transform.
// A class-based scoreboard predicts each projected point from its own copy of
// the coefficients and checks every done transaction. The coefficients are
// rewritten over APB between phases while the pipeline is empty. Points are
// sent in bursts of random length with random gaps between them.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hpt_pkg::*;

	typedef struct {
		logic [WORLD_W-1:0] wx;
		logic [WORLD_W-1:0] wy;
		logic [1:0]         st;
	} world_pt_t;

	class point_scoreboard;
		logic [COEF_W-1:0] coef [NUM_REGS];
		world_pt_t         pending [$];
		int                mismatches;

		function new();
			foreach (coef[i]) coef[i] = '0;
			coef[REG_XX] = COEF_ONE;
			coef[REG_YY] = COEF_ONE;
			mismatches = 0;
		endfunction

		function void set_coef(logic [2:0] idx, logic [DATA_W-1:0] val);
			coef[idx] = val[COEF_W-1:0];
		endfunction

		// Signed coefficient times unsigned pixel, exact in 128 bits.
		function logic signed [127:0] weigh(logic [2:0] idx, logic [PIX_W-1:0] pix);
			logic signed [127:0] c;
			logic signed [127:0] p;
			c = $signed(coef[idx]);
			p = $signed({112'd0, pix});
			return c * p;
		endfunction

		// Quotient num * 2^16 / den on magnitudes, truncated, saturated.
		function logic [WORLD_W-1:0] divide_sat(logic signed [127:0] num,
				logic signed [127:0] den, output bit sat);
			logic [127:0] mag;
			logic [127:0] q;
			logic [WORLD_W-1:0] qn;
			mag = (num < 0) ? -num : num;
			q = (mag << WORLD_FRAC) / $unsigned(den);
			sat = 1'b0;
			if (num < 0) begin
				if (q > {80'd0, WORLD_MIN}) begin
					sat = 1'b1;
					return WORLD_MIN;
				end
				qn = q[WORLD_W-1:0];
				return -qn;
			end
			if (q > {80'd0, WORLD_MAX}) begin
				sat = 1'b1;
				return WORLD_MAX;
			end
			return q[WORLD_W-1:0];
		endfunction

		function void note_point(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
			logic signed [127:0] den;
			logic signed [127:0] nx;
			logic signed [127:0] ny;
			world_pt_t e;
			bit sx;
			bit sy;
			den = weigh(REG_PX, x) + weigh(REG_PY, y) + (128'sd1 <<< (COEF_FRAC + PIX_FRAC));
			if (den <= 0) begin
				e.wx = '0;
				e.wy = '0;
				e.st = ST_BAD_DEN;
			end else begin
				nx = weigh(REG_XX, x) + weigh(REG_XY, y) + weigh(REG_XO, 16'd1 << PIX_FRAC);
				ny = weigh(REG_YX, x) + weigh(REG_YY, y) + weigh(REG_YO, 16'd1 << PIX_FRAC);
				e.wx = divide_sat(nx, den, sx);
				e.wy = divide_sat(ny, den, sy);
				e.st = (sx || sy) ? ST_SAT : ST_OK;
			end
			pending = {pending, e};
		endfunction

		function void check_result(logic [WORLD_W-1:0] wx, logic [WORLD_W-1:0] wy,
				logic [1:0] st);
			world_pt_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: x=%h y=%h status=%0d", wx, wy, st);
				return;
			end
			e = pending.pop_front();
			if (wx !== e.wx || wy !== e.wy || st !== e.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp x=%h y=%h st=%0d, got x=%h y=%h st=%0d",
						e.wx, e.wy, e.st, wx, wy, st);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [PIX_W-1:0]    pixel_x;
	logic [PIX_W-1:0]    pixel_y;
	logic                done;
	logic [WORLD_W-1:0]  world_x;
	logic [WORLD_W-1:0]  world_y;
	logic [1:0]          status;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	point_scoreboard sb = new();
	int unsigned     cycles = 0;

	homography_point_transform dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
		.world_x(world_x), .world_y(world_y), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("** homography_point_transform: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(world_x, world_y, status);
	end

	task automatic write_coef(logic [2:0] idx, logic [COEF_W-1:0] val);
		logic [DATA_W-1:0] data;
		// upper bits are don't-care in the register
		data = {16'($urandom_range(0, 65535)), val};
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_W'(idx) << 3;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_coef(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold start high; advance once the transaction is taken.
	task automatic send_point(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
		start   <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_point(x, y);
	endtask

	task automatic pause_sender(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		pause_sender(1);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [COEF_W-1:0] rand_coef(int mode);
		logic [COEF_W-1:0] v;
		v = COEF_W'({$urandom, $urandom});
		case (mode)
			1: v = {{14{v[34]}}, v[33:0]};
			2: v = {{24{v[24]}}, v[23:0]};
			3: v = WORLD_MAX;
			4: v = WORLD_MIN;
			default: ;
		endcase
		return v;
	endfunction

	task automatic random_points(int n);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				if (left > 0) begin
					send_point(PIX_W'($urandom_range(0, 65535)),
						PIX_W'($urandom_range(0, 65535)));
					left--;
				end
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 9));
		end
	endtask

	initial begin
		int mode;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity transform out of reset: pixel extremes
		send_point(16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'h0000);
		send_point(16'h0000, 16'hFFFF);
		send_point(16'h0001, 16'h8000);
		drain();

		// x = 1.0 makes the denominator zero, x = 2.0 makes it negative
		write_coef(REG_PX, -(COEF_ONE));
		send_point(16'h0010, 16'h1234);
		send_point(16'h0020, 16'h0000);
		send_point(16'h0008, 16'hFFFF);
		drain();

		// largest and smallest coefficients: saturate both ways
		for (int i = 0; i < NUM_REGS; i++)
			write_coef(3'(i), (i < 6) ? WORLD_MAX : 48'd0);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'h0000, 16'h0000);
		drain();
		for (int i = 0; i < 6; i++)
			write_coef(3'(i), WORLD_MIN);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'h0000, 16'h0001);
		send_point(16'h0000, 16'h0000);
		drain();
		write_coef(REG_PX, WORLD_MAX);
		write_coef(REG_PY, WORLD_MIN);
		send_point(16'h0000, 16'hFFFF);
		send_point(16'hFFFF, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0, 5: mode = 1;
				3:    mode = 3;
				4:    mode = 4;
				6:    mode = 0;
				default: mode = 2;
			endcase
			for (int i = 0; i < 6; i++)
				write_coef(3'(i), rand_coef(mode));
			// keep the projective terms small on most phases
			write_coef(REG_PX, (ph == 0) ? 48'd0 : rand_coef((ph >= 3 && ph <= 6) ? mode : 2));
			write_coef(REG_PY, (ph == 0) ? 48'd0 : rand_coef((ph >= 3 && ph <= 6) ? mode : 1));
			random_points(212);
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** homography_point_transform: PASSED **");
		else
			$display("** homography_point_transform: FAILED **");
		$finish;
	end

endmodule
